### hw/rtl/ima_pkg.sv
// Shared types, tables and nibble decode function for the IMA ADPCM loop decoder.
package ima_pkg;

	localparam int IDX_MAX = 88;

	typedef enum logic [1:0] {
		REG_LOOP_START  = 2'd0,
		REG_TOTAL_LEN   = 2'd1,
		REG_REPEAT_MODE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0]         idx;
	} nib_res_t;

	localparam logic [14:0] STEP_TBL [0:88] = '{
		15'h0007, 15'h0008, 15'h0009, 15'h000A, 15'h000B, 15'h000C, 15'h000D, 15'h000E,
		15'h0010, 15'h0011, 15'h0013, 15'h0015, 15'h0017, 15'h0019, 15'h001C, 15'h001F,
		15'h0022, 15'h0025, 15'h0029, 15'h002D, 15'h0032, 15'h0037, 15'h003C, 15'h0042,
		15'h0049, 15'h0050, 15'h0058, 15'h0061, 15'h006B, 15'h0076, 15'h0082, 15'h008F,
		15'h009D, 15'h00AD, 15'h00BE, 15'h00D1, 15'h00E6, 15'h00FD, 15'h0117, 15'h0133,
		15'h0151, 15'h0173, 15'h0198, 15'h01C1, 15'h01EE, 15'h0220, 15'h0256, 15'h0292,
		15'h02D4, 15'h031C, 15'h036C, 15'h03C3, 15'h0424, 15'h048E, 15'h0502, 15'h0583,
		15'h0610, 15'h06AB, 15'h0756, 15'h0812, 15'h08E0, 15'h09C3, 15'h0ABD, 15'h0BD0,
		15'h0CFF, 15'h0E4C, 15'h0FBA, 15'h114C, 15'h1307, 15'h14EE, 15'h1706, 15'h1954,
		15'h1BDC, 15'h1EA5, 15'h21B6, 15'h2515, 15'h28CA, 15'h2CDF, 15'h315B, 15'h364B,
		15'h3BB9, 15'h41B2, 15'h4844, 15'h4F7E, 15'h5771, 15'h602F, 15'h69CE, 15'h7462,
		15'h7FFF
	};

	localparam logic signed [7:0] IDX_ADJ [0:7] = '{
		-8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8
	};

	function automatic logic [6:0] clamp_idx(logic [6:0] idx);
		clamp_idx = (idx > 7'(IDX_MAX)) ? 7'(IDX_MAX) : idx;
	endfunction

	function automatic nib_res_t decode_nib(logic signed [15:0] pred, logic [6:0] idx,
			logic [3:0] nib);
		logic [14:0]        step;
		logic [16:0]        diff;
		logic signed [17:0] sum;
		logic signed [7:0]  nidx;
		nib_res_t           r;
		step = STEP_TBL[clamp_idx(idx)];
		diff = {5'b0, step[14:3]};
		if (nib[0]) diff = diff + {4'b0, step[14:2]};
		if (nib[1]) diff = diff + {3'b0, step[14:1]};
		if (nib[2]) diff = diff + {2'b0, step};
		if (nib[3]) begin
			sum = 18'(pred) - $signed({1'b0, diff});
			if (sum < -18'sd32767) sum = -18'sd32767;
		end else begin
			sum = 18'(pred) + $signed({1'b0, diff});
			if (sum > 18'sd32767) sum = 18'sd32767;
		end
		nidx = $signed({1'b0, clamp_idx(idx)}) + IDX_ADJ[nib[2:0]];
		if (nidx < 8'sd0) nidx = 8'sd0;
		if (nidx > 8'(IDX_MAX)) nidx = 8'(IDX_MAX);
		r.pred = sum[15:0];
		r.idx  = nidx[6:0];
		return r;
	endfunction

endpackage

### hw/rtl/ima_adpcm_loop_decoder.sv
// Top level of the IMA ADPCM 4-bit voice decoder with loop point.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------
//  item     | item_valid / item_ready   | cmd, data
//  result   | result_valid / result_ready | sample, last, playing
//  config   | cfg_wen                   | cfg_index, cfg_wdata
//
// An item lands in the s1 register; one shared nibble decoder works on it.
// A header, an ignored byte or the byte that stops a one-shot voice is finished
// in its first phase; any other data byte also runs a second phase (phase_s1),
// with one result beat per phase, so the next byte waits until both are out.
// A new item is taken in the cycle the s1 item finishes.
// Output stalls hold an s1 item that has a beat to emit; arst_n clears all control and voice state.
module ima_adpcm_loop_decoder import ima_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_wdata,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               cmd,
	input  logic [31:0]        data,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [15:0] sample,
	output logic               last,
	output logic               playing
);

	logic [17:0] loop_start_q;
	logic [23:0] total_len_q;
	logic [1:0]  repeat_mode_q;

	logic signed [15:0] pred_q, saved_pred_q;
	logic [6:0]         idx_q, saved_idx_q;
	logic [23:0]        offset_q;
	logic               active_q;

	logic        valid_s1, phase_s1, hold_s1, cmd_s1;
	logic [22:0] data_s1;

	logic signed [15:0] pred_d, saved_pred_d;
	logic [6:0]         idx_d, saved_idx_d;
	logic [23:0]        offset_d;
	logic               active_d, hold_d;
	logic               emit, emit_last, done, fire, out_free;
	logic signed [15:0] emit_sample;
	nib_res_t           nres;

	assign out_free   = !result_valid || result_ready;
	assign nres       = decode_nib(pred_q, idx_q, phase_s1 ? data_s1[7:4] : data_s1[3:0]);
	assign fire       = valid_s1 && (!emit || out_free);
	assign item_ready = !valid_s1 || (fire && done);

	always_comb begin
		pred_d       = pred_q;
		idx_d        = idx_q;
		saved_pred_d = saved_pred_q;
		saved_idx_d  = saved_idx_q;
		offset_d     = offset_q;
		active_d     = active_q;
		hold_d       = 1'b0;
		emit         = 1'b0;
		emit_last    = 1'b0;
		emit_sample  = pred_q;
		done         = 1'b0;
		if (!phase_s1) begin
			if (!cmd_s1) begin
				pred_d       = data_s1[15:0];
				idx_d        = clamp_idx(data_s1[22:16]);
				saved_pred_d = data_s1[15:0];
				saved_idx_d  = clamp_idx(data_s1[22:16]);
				offset_d     = 24'd4;
				active_d     = 1'b1;
				done         = 1'b1;
			end else if (!active_q) begin
				done = 1'b1;
			end else if (offset_q >= total_len_q) begin
				if (repeat_mode_q[0]) begin
					pred_d      = saved_pred_q;
					idx_d       = saved_idx_q;
					emit        = 1'b1;
					emit_sample = saved_pred_q;
					offset_d    = {6'b0, loop_start_q} + 24'd1;
				end else if (repeat_mode_q[1]) begin
					active_d    = 1'b0;
					emit        = 1'b1;
					emit_sample = '0;
					done        = 1'b1;
				end else begin
					emit   = 1'b1;
					hold_d = 1'b1;
				end
			end else begin
				pred_d      = nres.pred;
				idx_d       = nres.idx;
				emit        = 1'b1;
				emit_sample = nres.pred;
				offset_d    = offset_q + 24'd1;
				if (offset_q == {6'b0, loop_start_q}) begin
					saved_pred_d = nres.pred;
					saved_idx_d  = nres.idx;
				end
			end
		end else begin
			emit      = 1'b1;
			emit_last = 1'b1;
			done      = 1'b1;
			if (!hold_s1) begin
				pred_d      = nres.pred;
				idx_d       = nres.idx;
				emit_sample = nres.pred;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_start_q  <= '0;
			total_len_q   <= '0;
			repeat_mode_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_LOOP_START:  loop_start_q  <= cfg_wdata[17:0];
				REG_TOTAL_LEN:   total_len_q   <= cfg_wdata;
				REG_REPEAT_MODE: repeat_mode_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q       <= '0;
			idx_q        <= '0;
			saved_pred_q <= '0;
			saved_idx_q  <= '0;
			offset_q     <= '0;
			active_q     <= 1'b0;
			phase_s1     <= 1'b0;
			hold_s1      <= 1'b0;
		end else if (fire) begin
			pred_q       <= pred_d;
			idx_q        <= idx_d;
			saved_pred_q <= saved_pred_d;
			saved_idx_q  <= saved_idx_d;
			offset_q     <= offset_d;
			active_q     <= active_d;
			phase_s1     <= !done;
			hold_s1      <= hold_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1  <= cmd;
			data_s1 <= data[22:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && emit) begin
			sample  <= emit_sample;
			last    <= emit_last;
			playing <= active_d;
		end
	end

endmodule

### hw/rtl/ima_chk.sv
// Port-level assertion checker for the IMA ADPCM loop decoder, with its bind.
module ima_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [15:0] sample,
	input logic               last,
	input logic               playing
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(sample) && $stable(last))
		else $error("result beat changed while stalled");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !playing |-> sample == 16'sd0 && !last)
		else $error("stop beat not a zero low-nibble sample");

	a_last_playing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> playing)
		else $error("high-nibble beat with voice idle");

	a_last_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last && playing |=> !(result_valid && !last))
		else $error("low-nibble beat not followed by its high-nibble beat");

endmodule

bind ima_adpcm_loop_decoder ima_chk u_ima_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.sample       (sample),
	.last         (last),
	.playing      (playing)
);

### verif/tb_top.sv
// Self-checking bench for the IMA ADPCM loop decoder: headers, data bytes and end modes.
module tb_top;
	import ima_pkg::*;

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_BYTE   = 1'b1;

	localparam logic [1:0] MODE_HOLD    = 2'd0;
	localparam logic [1:0] MODE_LOOP    = 2'd1;
	localparam logic [1:0] MODE_ONESHOT = 2'd2;
	localparam logic [1:0] MODE_BOTH    = 2'd3;

	localparam logic [17:0] LOOP_START_MAX = 18'd262140;
	localparam logic [23:0] TOTAL_LEN_MAX  = 24'd8650748;
	localparam int          VOICE_ITEMS    = 1850;
	localparam int          QUIET_LIMIT    = 1000;
	localparam int          PRINT_CAP      = 40;

	localparam int STEP_SIZE [0:88] = '{
		'h0007, 'h0008, 'h0009, 'h000A, 'h000B, 'h000C, 'h000D, 'h000E,
		'h0010, 'h0011, 'h0013, 'h0015, 'h0017, 'h0019, 'h001C, 'h001F,
		'h0022, 'h0025, 'h0029, 'h002D, 'h0032, 'h0037, 'h003C, 'h0042,
		'h0049, 'h0050, 'h0058, 'h0061, 'h006B, 'h0076, 'h0082, 'h008F,
		'h009D, 'h00AD, 'h00BE, 'h00D1, 'h00E6, 'h00FD, 'h0117, 'h0133,
		'h0151, 'h0173, 'h0198, 'h01C1, 'h01EE, 'h0220, 'h0256, 'h0292,
		'h02D4, 'h031C, 'h036C, 'h03C3, 'h0424, 'h048E, 'h0502, 'h0583,
		'h0610, 'h06AB, 'h0756, 'h0812, 'h08E0, 'h09C3, 'h0ABD, 'h0BD0,
		'h0CFF, 'h0E4C, 'h0FBA, 'h114C, 'h1307, 'h14EE, 'h1706, 'h1954,
		'h1BDC, 'h1EA5, 'h21B6, 'h2515, 'h28CA, 'h2CDF, 'h315B, 'h364B,
		'h3BB9, 'h41B2, 'h4844, 'h4F7E, 'h5771, 'h602F, 'h69CE, 'h7462,
		'h7FFF
	};

	typedef struct packed {
		logic signed [15:0] pcm;
		logic               last;
		logic               playing;
	} pcm_beat_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wen;
	logic [1:0]         cfg_index;
	logic [23:0]        cfg_wdata;
	logic               item_valid;
	logic               item_ready;
	logic               cmd;
	logic [31:0]        data;
	logic               result_valid;
	logic               result_ready;
	logic signed [15:0] sample;
	logic               last;
	logic               playing;

	ima_adpcm_loop_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.cmd          (cmd),
		.data         (data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample       (sample),
		.last         (last),
		.playing      (playing)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// voice model state and register copies
	int          v_pred, v_index, v_saved_pred, v_saved_index;
	logic [23:0] v_offset = '0;
	logic        v_on = 1'b0;
	logic [17:0] r_loop_start = '0;
	logic [23:0] r_total_len = '0;
	logic [1:0]  r_mode = MODE_HOLD;

	pcm_beat_t pcm_q [$];
	int        errors, beats_checked, voice_items, wraps, stops, holds, quiet;
	int        gap_rate, stall_rate;
	bit        calm;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < PRINT_CAP)
			$display("mismatch %s: got %0d, want %0d (beat %0d)", what, got, want, beats_checked);
		errors++;
	endtask

	task automatic apply_nibble(input logic [3:0] nib);
		int st, diff;
		st = STEP_SIZE[v_index];
		diff = st >> 3;
		if (nib[0]) diff += st >> 2;
		if (nib[1]) diff += st >> 1;
		if (nib[2]) diff += st;
		if (nib[3]) v_pred = (v_pred - diff < -32767) ? -32767 : v_pred - diff;
		else v_pred = (v_pred + diff > 32767) ? 32767 : v_pred + diff;
		if (nib[2]) v_index += 2 * (int'(nib[1:0]) + 1);
		else v_index -= 1;
		if (v_index < 0) v_index = 0;
		if (v_index > IDX_MAX) v_index = IDX_MAX;
	endtask

	function automatic void push_beat(input int pcm, input logic lst);
		pcm_beat_t b;
		b.pcm = 16'(pcm);
		b.last = lst;
		b.playing = v_on;
		pcm_q.push_back(b);
	endfunction

	task automatic predict_voice(input logic c, input logic [31:0] d);
		if (c == CMD_HEADER) begin
			v_pred = int'($signed(d[15:0]));
			v_index = (int'(d[22:16]) > IDX_MAX) ? IDX_MAX : int'(d[22:16]);
			v_saved_pred = v_pred;
			v_saved_index = v_index;
			v_offset = 24'd4;
			v_on = 1'b1;
			voice_items++;
		end else if (v_on) begin
			voice_items++;
			if (v_offset >= r_total_len) begin
				if (r_mode[0]) begin
					v_pred = v_saved_pred;
					v_index = v_saved_index;
					push_beat(v_pred, 1'b0);
					apply_nibble(d[7:4]);
					push_beat(v_pred, 1'b1);
					v_offset = {6'd0, r_loop_start} + 24'd1;
					wraps++;
				end else if (r_mode[1]) begin
					v_on = 1'b0;
					push_beat(0, 1'b0);
					stops++;
				end else begin
					push_beat(v_pred, 1'b0);
					push_beat(v_pred, 1'b1);
					holds++;
				end
			end else begin
				apply_nibble(d[3:0]);
				if (v_offset == {6'd0, r_loop_start}) begin
					v_saved_pred = v_pred;
					v_saved_index = v_index;
				end
				push_beat(v_pred, 1'b0);
				apply_nibble(d[7:4]);
				push_beat(v_pred, 1'b1);
				v_offset = v_offset + 24'd1;
			end
		end
	endtask

	task automatic send_item(input logic c, input logic [31:0] d);
		if (!calm && $urandom_range(0, 99) < gap_rate) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		data <= d;
		do @(posedge clk); while (!item_ready);
		predict_voice(c, d);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pcm_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [17:0] ls, input logic [23:0] tl, input logic [1:0] m);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_index <= REG_LOOP_START;
		cfg_wdata <= {6'd0, ls};
		@(posedge clk);
		cfg_index <= REG_TOTAL_LEN;
		cfg_wdata <= tl;
		@(posedge clk);
		cfg_index <= REG_REPEAT_MODE;
		cfg_wdata <= {22'd0, m};
		@(posedge clk);
		cfg_wen <= 1'b0;
		r_loop_start = ls;
		r_total_len = tl;
		r_mode = m;
	endtask

	function automatic logic [31:0] rand_header();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 7))
			0: w[15:0] = 16'h8000;
			1: w[15:0] = 16'h7FFF;
			2: w[15:0] = 16'h8001;
			default: ;
		endcase
		if ($urandom_range(0, 7) != 0) w[22:16] = 7'($urandom_range(0, IDX_MAX));
		return w;
	endfunction

	function automatic logic [31:0] rand_byte();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 15))
			0: w[7:0] = 8'h77;
			1: w[7:0] = 8'hFF;
			2: w[7:0] = 8'h00;
			3: w[7:0] = 8'h88;
			default: ;
		endcase
		return w;
	endfunction

	// bytes before any header must be dropped
	task automatic test_idle_bytes();
		send_item(CMD_BYTE, 32'h0000_0000);
		send_item(CMD_BYTE, 32'hFFFF_FFFF);
	endtask

	task automatic test_saturation();
		set_regs(18'd0, 24'd40, MODE_LOOP);
		send_item(CMD_HEADER, 32'h0058_7FFF);
		send_item(CMD_BYTE, 32'h0000_0077);
		send_item(CMD_BYTE, 32'h0000_0077);
		send_item(CMD_HEADER, 32'hFFFF_8000);
		send_item(CMD_BYTE, 32'h0000_00FF);
		send_item(CMD_BYTE, 32'h0000_00FF);
		send_item(CMD_HEADER, 32'h0000_0000);
		send_item(CMD_BYTE, 32'h0000_0088);
		send_item(CMD_BYTE, 32'h0000_0000);
	endtask

	task automatic test_end_modes();
		set_regs(18'd5, 24'd8, MODE_LOOP);
		send_item(CMD_HEADER, rand_header());
		repeat (6) send_item(CMD_BYTE, rand_byte());
		// loop point inside the header, restore of a -32768 predictor
		set_regs(18'd2, 24'd4, MODE_BOTH);
		send_item(CMD_HEADER, 32'h0010_8000);
		send_item(CMD_BYTE, rand_byte());
		set_regs(18'd3, 24'd5, MODE_ONESHOT);
		send_item(CMD_HEADER, rand_header());
		repeat (3) send_item(CMD_BYTE, rand_byte());
		set_regs(18'd0, 24'd4, MODE_HOLD);
		send_item(CMD_HEADER, 32'h0000_8000);
		send_item(CMD_BYTE, rand_byte());
		send_item(CMD_HEADER, rand_header());
		send_item(CMD_BYTE, rand_byte());
	endtask

	task automatic test_reg_extremes();
		set_regs(LOOP_START_MAX, 24'd0, MODE_LOOP);
		send_item(CMD_HEADER, rand_header());
		send_item(CMD_BYTE, rand_byte());
		send_item(CMD_BYTE, rand_byte());
		set_regs(18'd0, TOTAL_LEN_MAX, MODE_ONESHOT);
		send_item(CMD_HEADER, rand_header());
		send_item(CMD_BYTE, rand_byte());
	endtask

	task automatic test_random();
		int goal, n, r;
		logic [23:0] tl;
		logic [17:0] ls;
		goal = voice_items + VOICE_ITEMS;
		while (voice_items < goal) begin
			calm = (voice_items >= goal - VOICE_ITEMS / 8);
			case ($urandom_range(0, 11))
				0: tl = 24'd0;
				1: tl = TOTAL_LEN_MAX;
				2: tl = 24'($urandom_range(0, TOTAL_LEN_MAX));
				default: tl = 24'($urandom_range(4, 40));
			endcase
			case ($urandom_range(0, 11))
				0: ls = LOOP_START_MAX;
				1: ls = 18'($urandom_range(0, LOOP_START_MAX));
				default: ls = 18'($urandom_range(0, 44));
			endcase
			set_regs(ls, tl, 2'($urandom_range(0, 3)));
			case ($urandom_range(0, 2))
				0: gap_rate = 0;
				1: gap_rate = 10;
				default: gap_rate = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_rate = 0;
				1: stall_rate = 10;
				default: stall_rate = 40;
			endcase
			send_item(CMD_HEADER, rand_header());
			n = $urandom_range(4, 48);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 3 || (!v_on && r < 40)) send_item(CMD_HEADER, rand_header());
				else if (r < 7) send_item(1'($urandom_range(0, 1)), $urandom);
				else send_item(CMD_BYTE, rand_byte());
			end
		end
	endtask

	initial begin
		int hold_left;
		result_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= (hold_left == 0);
			end else if (!calm && $urandom_range(0, 99) < stall_rate) begin
				hold_left = $urandom_range(1, 15);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pcm_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pcm_q.size() == 0) begin
				report_mismatch("beat with nothing pending, sample", sample, 0);
			end else begin
				want = pcm_q.pop_front();
				if (sample !== want.pcm) report_mismatch("sample", sample, want.pcm);
				if (last !== want.last) report_mismatch("last", last, want.last);
				if (playing !== want.playing) report_mismatch("playing", playing, want.playing);
				beats_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_LOOP_START;
		cfg_wdata = '0;
		item_valid = 1'b0;
		cmd = CMD_HEADER;
		data = '0;
		gap_rate = 20;
		stall_rate = 20;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_saturation();
		test_end_modes();
		test_reg_extremes();
		test_random();
		wait_drained();
		repeat (10) @(posedge clk);
		$display("covered %0d voice items, %0d samples compared", voice_items, beats_checked);
		$display("end of data: %0d loop wraps, %0d one-shot stops, %0d holds",
			wraps, stops, holds);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
